[rtl/core/bfa_pkg.sv]
package bfa_pkg;

    localparam int WORD_BITS  = 8;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int START_W    = 32;
    localparam int END_W      = 33;
    localparam int FADDR_W    = 28;
    localparam int FREE_W     = 17;
    localparam int LIMIT_W    = 29;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 80;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 29'h1FFF_FFFF;
    localparam logic [END_W-1:0]   CLAMP_END = 33'h0_FFFF_FFFF;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_RESERVE = 2'd2,
        FN_RELEASE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        WM_FIND  = 2'd0,
        WM_SET   = 2'd1,
        WM_CLEAR = 2'd2
    } wmode_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SETUP,
        ST_ARD,
        ST_ACHK,
        ST_RRD,
        ST_RMW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic                 found;
        logic [IDX_W-1:0]     first_idx;
        logic [IDX_W-1:0]     top_idx;
        logic [CNT_W-1:0]     changed;
    } word_res_t;

endpackage

[rtl/core/bfa_ram.sv]
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bfa_word_unit.sv]
module bfa_word_unit import bfa_pkg::*; (
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] mask,
    input  wmode_t               mode,
    output word_res_t            res
);

    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] chg;
    logic                 hit;
    logic [IDX_W-1:0]     first;
    logic [IDX_W-1:0]     top;
    logic [CNT_W-1:0]     cnt;

    always_comb begin
        cand  = '0;
        chg   = '0;
        hit   = 1'b0;
        first = '0;
        top   = '0;
        cnt   = '0;
        case (mode)
            WM_FIND:  cand = mask & ~word;
            WM_SET:   cand = mask & ~word;
            WM_CLEAR: cand = mask & word;
            default:  cand = '0;
        endcase
        // lowest candidate bit
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit   = 1'b1;
                first = IDX_W'(i);
            end
        end
        if (mode == WM_FIND) begin
            chg = hit ? (WORD_BITS'(1) << first) : '0;
        end else begin
            chg = cand;
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            cnt = cnt + CNT_W'(chg[i]);
            if (chg[i]) begin
                top = IDX_W'(i);
            end
        end
        res.found     = hit;
        res.first_idx = first;
        res.top_idx   = top;
        res.changed   = cnt;
        res.new_word  = (mode == WM_CLEAR) ? (word & ~chg) : (word | chg);
    end

endmodule

[rtl/core/bitmap_frame_allocator_core.sv]
// Bitmap frame allocator, next fit. One bit per frame (1 = used) sits in a
// RAM of 8-bit words; every request but one with an empty range is a
// read-modify-write sweep over those words by one shared word unit (mask,
// priority find, popcount). After reset a fill pass writes every word to all
// ones, and no request is taken meanwhile; every frame starts used with a
// free count of zero. Free, reserve and release read and then rewrite each
// bitmap word touched; allocate reads and checks each word visited from the
// cursor, up to ceil(NUM_FRAMES/8)+1 words when the map is full. Each word
// needs a read state, then a check or write state (registered RAM read). One
// request is in flight at a time; s_tready is high only when idle. A result
// holds in the output register until taken. FRAME_BYTES must be a power of
// two. free_frames is the low 17 bits of the internal count.
module bitmap_frame_allocator_core import bfa_pkg::*; #(
    parameter int NUM_FRAMES  = 65536,
    parameter int FRAME_BYTES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] start_addr, [64:32] end_addr, upper bits zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [27:0] frame_addr, [44:28] free_frames, [73:45] highest_ram, rest zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [0] status
    output logic [0:0]          m_tuser
);

    localparam int NWORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = $clog2(NWORDS > 1 ? NWORDS : 2);
    localparam int FW     = $clog2(NUM_FRAMES) + 1;
    localparam int SH     = $clog2(FRAME_BYTES);
    localparam int VW     = $clog2(NWORDS + 1);
    localparam int TW     = (FW + SH + 1 > 30) ? FW + SH + 1 : 30;
    localparam int XW     = 34;

    state_t state_reg, state_next;
    logic [1:0]         func_reg, func_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [END_W-1:0]   end_reg, end_next;
    logic [FW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      wcur_reg, wcur_next;
    logic [AW-1:0]      wlast_reg, wlast_next;
    logic [VW-1:0]      visit_reg, visit_next;
    logic [FW-1:0]      cursor_reg, cursor_next;
    logic [FW-1:0]      hi_reg, hi_next;
    logic [FW-1:0]      free_reg, free_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               stat_reg, stat_next;
    logic [FADDR_W-1:0] faddr_reg, faddr_next;
    logic               mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0] mdata_reg, mdata_next;
    logic               muser_reg, muser_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [WORD_BITS-1:0] u_mask;
    wmode_t             u_mode;
    word_res_t          u_res;

    logic [XW-1:0]      lo_x, hi_x, endc_x;
    logic               rng_ok;
    logic [FW-1:0]      hi_cap, hi_m1;
    logic [IDX_W-1:0]   cbit;
    logic [TW-1:0]      fidx_t, top_t;
    logic [FW-1:0]      fidx_f;
    logic [WORD_BITS-1:0] lo_mask, hi_mask;

    bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_word_unit u_word (
        .word (ram_rdata),
        .mask (u_mask),
        .mode (u_mode),
        .res  (u_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // Range bounds in frames; hi is capped at NUM_FRAMES.
    always_comb begin
        lo_x   = XW'(start_reg) >> SH;
        endc_x = (end_reg > CLAMP_END) ? XW'(CLAMP_END) : XW'(end_reg);
        hi_x   = '0;
        rng_ok = 1'b0;
        case (func_t'(func_reg))
            FN_FREE: begin
                hi_x   = lo_x + XW'(1);
                rng_ok = 1'b1;
            end
            FN_RESERVE: begin
                hi_x   = (XW'(end_reg) + XW'(FRAME_BYTES - 1)) >> SH;
                rng_ok = (end_reg > END_W'(start_reg));
            end
            FN_RELEASE: begin
                hi_x   = endc_x >> SH;
                rng_ok = (endc_x > XW'(start_reg));
            end
            default: begin
                hi_x   = '0;
                rng_ok = 1'b0;
            end
        endcase
        hi_cap = (hi_x > XW'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : FW'(hi_x);
        rng_ok = rng_ok && (lo_x < XW'(hi_cap));
    end

    assign cbit   = cursor_reg[IDX_W-1:0];
    assign hi_m1  = hi_reg - FW'(1);
    assign fidx_t = TW'({wcur_reg, u_res.first_idx});
    assign fidx_f = FW'({wcur_reg, u_res.first_idx});
    assign top_t  = (TW'({wcur_reg, u_res.top_idx}) + TW'(1)) << SH;
    assign lo_mask = (wcur_reg == AW'(lo_reg >> IDX_W)) ?
                     (WORD_BITS'(8'hFF) << lo_reg[IDX_W-1:0]) : WORD_BITS'(8'hFF);
    assign hi_mask = (wcur_reg == wlast_reg) ?
                     (WORD_BITS'(8'hFF) >> (IDX_W'(WORD_BITS - 1) - hi_m1[IDX_W-1:0])) :
                     WORD_BITS'(8'hFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL;
            wcur_reg   <= '0;
            cursor_reg <= '0;
            free_reg   <= '0;
            limit_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wcur_reg   <= wcur_next;
            cursor_reg <= cursor_next;
            free_reg   <= free_next;
            limit_reg  <= limit_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        wlast_reg <= wlast_next;
        visit_reg <= visit_next;
        stat_reg  <= stat_next;
        faddr_reg <= faddr_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        wcur_next   = wcur_reg;
        wlast_next  = wlast_reg;
        visit_next  = visit_reg;
        cursor_next = cursor_reg;
        free_next   = free_reg;
        limit_next  = limit_reg;
        stat_next   = stat_reg;
        faddr_next  = faddr_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        ram_we      = 1'b0;
        ram_waddr   = wcur_reg;
        ram_wdata   = u_res.new_word;
        ram_raddr   = wcur_reg;
        u_mask      = WORD_BITS'(8'hFF);
        u_mode      = WM_FIND;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL: begin
                // power-up sweep: every frame used
                ram_we    = 1'b1;
                ram_wdata = '1;
                if (wcur_reg == AW'(NWORDS - 1)) begin
                    wcur_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    wcur_next = wcur_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    start_next = s_tdata[START_W-1:0];
                    end_next   = s_tdata[START_W+END_W-1:START_W];
                    stat_next  = 1'b0;
                    faddr_next = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (func_t'(func_reg) == FN_ALLOC) begin
                    stat_next  = 1'b1;
                    wcur_next  = AW'(cursor_reg >> IDX_W);
                    visit_next = '0;
                    state_next = ST_ARD;
                end else if (rng_ok) begin
                    lo_next    = FW'(lo_x);
                    hi_next    = hi_cap;
                    wcur_next  = AW'(FW'(lo_x) >> IDX_W);
                    wlast_next = AW'((hi_cap - FW'(1)) >> IDX_W);
                    state_next = ST_RRD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ARD: begin
                state_next = ST_ACHK;
            end
            ST_ACHK: begin
                // first visit skips bits below the cursor, last visit takes only them
                u_mode = WM_FIND;
                if (visit_reg == '0) begin
                    u_mask = WORD_BITS'(8'hFF) << cbit;
                end else if (visit_reg == VW'(NWORDS)) begin
                    u_mask = ~(WORD_BITS'(8'hFF) << cbit);
                end else begin
                    u_mask = WORD_BITS'(8'hFF);
                end
                if (u_res.found) begin
                    ram_we      = 1'b1;
                    free_next   = free_reg - FW'(1);
                    stat_next   = 1'b0;
                    faddr_next  = FADDR_W'(fidx_t << SH);
                    cursor_next = (fidx_f + FW'(1) >= FW'(NUM_FRAMES)) ?
                                  '0 : fidx_f + FW'(1);
                    state_next  = ST_DONE;
                end else if (visit_reg == VW'(NWORDS)) begin
                    state_next = ST_DONE;
                end else begin
                    visit_next = visit_reg + VW'(1);
                    wcur_next  = (wcur_reg == AW'(NWORDS - 1)) ? '0 : wcur_reg + AW'(1);
                    state_next = ST_ARD;
                end
            end
            ST_RRD: begin
                state_next = ST_RMW;
            end
            ST_RMW: begin
                u_mask = lo_mask & hi_mask;
                u_mode = (func_t'(func_reg) == FN_RESERVE) ? WM_SET : WM_CLEAR;
                ram_we = 1'b1;
                if (u_mode == WM_SET) begin
                    free_next = free_reg - FW'(u_res.changed);
                end else begin
                    free_next = free_reg + FW'(u_res.changed);
                    if (u_res.changed != '0) begin
                        if (top_t > TW'(LIMIT_MAX)) begin
                            limit_next = LIMIT_MAX;
                        end else if (LIMIT_W'(top_t) > limit_reg) begin
                            limit_next = LIMIT_W'(top_t);
                        end
                    end
                end
                if (wcur_reg == wlast_reg) begin
                    state_next = ST_DONE;
                end else begin
                    wcur_next  = wcur_reg + AW'(1);
                    state_next = ST_RRD;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    muser_next  = stat_reg;
                    mdata_next  = {6'd0, limit_reg, FREE_W'(free_reg), faddr_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Count never exceeds the tracked frames.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FW'(NUM_FRAMES))
        else $error("free count above frame count");

    // One request at a time: no accept right after an accept.
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // A failed allocate reports a zero address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && muser_reg) |-> (mdata_reg[FADDR_W-1:0] == '0))
        else $error("failed allocate with nonzero address");

    // Cursor stays inside the map.
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg < FW'(NUM_FRAMES))
        else $error("cursor out of range");

endmodule
